### rtl/inverse_gaussian_variate_defines.svh
// Assertion macros for the inverse Gaussian variate block.
`ifndef INVERSE_GAUSSIAN_VARIATE_DEFINES_SVH
`define INVERSE_GAUSSIAN_VARIATE_DEFINES_SVH

// Check a same-cycle implication.
`define IGV_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("igv check failed");

// Check an implication in the following cycle.
`define IGV_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("igv sequence failed");

`endif

### rtl/igv_pkg.sv
// Package with constants, pipeline word types and helpers of the inverse Gaussian block.
`default_nettype none
package igv_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [31:0] ONE_VALUE = 32'(1) << FRAC_BITS;

  localparam logic [7:0] REG_MEAN  = 8'd0;
  localparam logic [7:0] REG_SHAPE = 8'd1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DEG = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [15:0] u;
    logic [29:0] wp;
    logic [29:0] lp;
    logic [61:0] num;
  } core_t;

  typedef struct packed {
    logic [15:0] u;
    logic [33:0] d;
    logic [62:0] rem;
    logic [31:0] q;
  } div1_t;

  typedef struct packed {
    logic [31:0] x;
    logic        acc;
    logic        sat;
    logic [63:0] rem;
    logic [31:0] q;
  } div2_t;

  function automatic logic [5:0] shift_count(logic [62:0] v);
    logic [5:0] k;
    k = 6'd0;
    for (int i = 30; i < 63; i++) begin
      if (v[i]) k = 6'(i - 29);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

### rtl/inverse_gaussian_variate.sv
// Top level of the pipelined inverse Gaussian variate generator.
// One word is accepted every cycle (busy never rises) and each result appears on
// variate and status with strobe high after passing the input registers, the
// 32-step square root pipeline and the two 32-step divider pipelines. The receiver
// cannot stall: every result is shown for one cycle only.
// Write mean_value (index 0) and shape_value (index 1) only while no word is in flight.
`default_nettype none
`include "inverse_gaussian_variate_defines.svh"
module inverse_gaussian_variate import igv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] normal_sample,
  input  wire logic        [15:0] uniform_sample,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [7:0]  cfg_index,
  input  wire logic        [31:0] cfg_data,
  output logic                    strobe,
  output logic             [31:0] variate,
  output logic             [1:0]  status
);

  logic [31:0] mean_value, shape_value;
  logic [62:0] lf;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign lf        = {7'b0, shape_value, 24'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_value  <= ONE_VALUE;
      shape_value <= ONE_VALUE;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MEAN) mean_value <= cfg_data;
      if (cfg_index == REG_SHAPE) shape_value <= cfg_data;
    end
  end

  logic               v1, v2, v3, v4, v5, v6, v7;
  logic signed [15:0] n1;
  logic [15:0]        u1, u2, u3, u4, u5, u6, u7;
  logic [15:0]        mag;
  logic [30:0]        y2;
  logic [62:0]        wf3, wf4;
  logic [5:0]         k4;
  logic [29:0]        wp5, lp5, wp6, lp6, wp7, lp7;
  logic [59:0]        p1, p2;
  logic [61:0]        num6, num7;
  logic [63:0]        v7r;

  assign mag = n1[15] ? 16'(-n1) : 16'(n1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    n1   <= normal_sample;
    u1   <= uniform_sample;
    y2   <= 31'({16'b0, mag} * {16'b0, mag});
    u2   <= u1;
    wf3  <= 63'({31'b0, mean_value} * {32'b0, y2});
    u3   <= u2;
    k4   <= shift_count(wf3 | lf);
    wf4  <= wf3;
    u4   <= u3;
    wp5  <= 30'(wf4 >> k4);
    lp5  <= 30'(lf >> k4);
    u5   <= u4;
    p1   <= {30'b0, wp5} * {30'b0, wp5};
    p2   <= {30'b0, lp5} * {30'b0, wp5};
    num6 <= {30'b0, mean_value} * {32'b0, lp5};
    wp6  <= wp5;
    lp6  <= lp5;
    u6   <= u5;
    v7r  <= 64'(p1) + (64'(p2) << 2);
    wp7  <= wp6;
    lp7  <= lp6;
    num7 <= num6;
    u7   <= u6;
  end

  logic        sq_vld  [0:SQ_STEPS];
  core_t       sq_c    [0:SQ_STEPS];
  logic [63:0] sq_rem  [0:SQ_STEPS];
  logic [63:0] sq_root [0:SQ_STEPS];

  assign sq_vld[0]  = v7;
  assign sq_c[0]    = '{u: u7, wp: wp7, lp: lp7, num: num7};
  assign sq_rem[0]  = v7r;
  assign sq_root[0] = 64'd0;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    assign trial = sq_root[i] + BIT;
    always_ff @(posedge clk) begin
      if (rst) sq_vld[i+1] <= 1'b0;
      else     sq_vld[i+1] <= sq_vld[i];
    end
    always_ff @(posedge clk) begin
      sq_c[i+1] <= sq_c[i];
      if (sq_rem[i] >= trial) begin
        sq_rem[i+1]  <= sq_rem[i] - trial;
        sq_root[i+1] <= (sq_root[i] >> 1) + BIT;
      end else begin
        sq_rem[i+1]  <= sq_rem[i];
        sq_root[i+1] <= sq_root[i] >> 1;
      end
    end
  end

  logic  d_vld;
  div1_t dv1    [0:DIV_STEPS];
  logic  dv1_vld[0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else     d_vld <= sq_vld[SQ_STEPS];
  end

  always_ff @(posedge clk) begin
    dv1[0].u   <= sq_c[SQ_STEPS].u;
    dv1[0].d   <= 34'({sq_c[SQ_STEPS].lp, 1'b0}) + 34'(sq_c[SQ_STEPS].wp)
                + 34'(sq_root[SQ_STEPS]);
    dv1[0].rem <= {sq_c[SQ_STEPS].num, 1'b0};
    dv1[0].q   <= 32'd0;
  end

  assign dv1_vld[0] = d_vld;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div1
    localparam int B = DIV_STEPS - 1 - i;
    logic [65:0] sh, remx;
    assign sh   = 66'(dv1[i].d) << B;
    assign remx = 66'(dv1[i].rem);
    always_ff @(posedge clk) begin
      if (rst) dv1_vld[i+1] <= 1'b0;
      else     dv1_vld[i+1] <= dv1_vld[i];
    end
    always_ff @(posedge clk) begin
      dv1[i+1].u <= dv1[i].u;
      dv1[i+1].d <= dv1[i].d;
      if (remx >= sh) begin
        dv1[i+1].rem <= 63'(remx - sh);
        dv1[i+1].q   <= dv1[i].q | (32'd1 << B);
      end else begin
        dv1[i+1].rem <= dv1[i].rem;
        dv1[i+1].q   <= dv1[i].q;
      end
    end
  end

  logic        a_vld, a_acc;
  logic [31:0] a_x;
  logic [63:0] a_musq;
  logic [32:0] a_sum;

  assign a_sum = 33'(mean_value) + 33'(dv1[DIV_STEPS].q);

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else     a_vld <= dv1_vld[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    a_x    <= dv1[DIV_STEPS].q;
    a_acc  <= ({33'b0, dv1[DIV_STEPS].u} * {16'b0, a_sum}) <= {1'b0, mean_value, 16'b0};
    a_musq <= {32'b0, mean_value} * {32'b0, mean_value};
  end

  div2_t dv2    [0:DIV_STEPS];
  logic  dv2_vld[0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) dv2_vld[0] <= 1'b0;
    else     dv2_vld[0] <= a_vld;
  end

  always_ff @(posedge clk) begin
    dv2[0].x   <= a_x;
    dv2[0].acc <= a_acc;
    dv2[0].sat <= a_musq[63:32] >= a_x;
    dv2[0].rem <= a_musq;
    dv2[0].q   <= 32'd0;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div2
    localparam int B = DIV_STEPS - 1 - i;
    logic [63:0] sh;
    assign sh = 64'(dv2[i].x) << B;
    always_ff @(posedge clk) begin
      if (rst) dv2_vld[i+1] <= 1'b0;
      else     dv2_vld[i+1] <= dv2_vld[i];
    end
    always_ff @(posedge clk) begin
      dv2[i+1].x   <= dv2[i].x;
      dv2[i+1].acc <= dv2[i].acc;
      dv2[i+1].sat <= dv2[i].sat;
      if (dv2[i].rem >= sh) begin
        dv2[i+1].rem <= dv2[i].rem - sh;
        dv2[i+1].q   <= dv2[i].q | (32'd1 << B);
      end else begin
        dv2[i+1].rem <= dv2[i].rem;
        dv2[i+1].q   <= dv2[i].q;
      end
    end
  end

  div2_t fin;
  assign fin = dv2[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= dv2_vld[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (shape_value == 32'd0 || mean_value == 32'd0) begin
      variate <= 32'd0;
      status  <= ST_DEG;
    end else if (fin.acc) begin
      variate <= fin.x;
      status  <= ST_OK;
    end else if (fin.x == 32'd0) begin
      variate <= 32'd0;
      status  <= ST_DEG;
    end else if (fin.sat) begin
      variate <= 32'hFFFF_FFFF;
      status  <= ST_SAT;
    end else begin
      variate <= fin.q;
      status  <= ST_OK;
    end
  end

  `IGV_CHECK(a_sat_ones, strobe && status == ST_SAT, variate == 32'hFFFF_FFFF)
  `IGV_CHECK(a_deg_zero, strobe && status == ST_DEG, variate == 32'd0)
  `IGV_NEXT(a_root_to_div, sq_vld[SQ_STEPS], d_vld)

endmodule
`default_nettype wire
